>>> hw/rtl/srvemu_pkg.sv
// ----------------------------------------------------------------------------
// Servo drive emulator package
// Register indexes, command and status codes, beat payload types and the
// signed saturation helper shared by the emulator modules.
// ----------------------------------------------------------------------------
package srvemu_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int WIDE_W      = 56;

    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_POSITION  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DEVIATION  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CYCLE_RATE     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CYCLE_PERIOD   = 2'd3;

    localparam logic [2:0] CMD_UNKNOWN = 3'd0;
    localparam logic [2:0] CMD_SYNC    = 3'd1;
    localparam logic [2:0] CMD_OFF     = 3'd2;
    localparam logic [2:0] CMD_CSP     = 3'd3;
    localparam logic [2:0] CMD_CST     = 3'd4;
    localparam logic [2:0] CMD_CSV     = 3'd5;

    localparam logic [2:0] ST_NOTREADY = 3'd0;
    localparam logic [2:0] ST_LOGIC    = 3'd1;
    localparam logic [2:0] ST_LOCKED   = 3'd2;
    localparam logic [2:0] ST_CSP      = 3'd3;
    localparam logic [2:0] ST_CST      = 3'd4;
    localparam logic [2:0] ST_CSV      = 3'd5;
    localparam logic [2:0] ST_ERROR    = 3'd6;
    localparam logic [2:0] ST_UNUSED   = 3'd7;

    localparam logic [30:0] MAX_DEVIATION_RESET = 31'd1000;
    localparam logic [19:0] CYCLE_RATE_RESET    = 20'd1000;
    localparam logic [31:0] CYCLE_PERIOD_RESET  = 32'd4294967;

    localparam logic signed [WIDE_W-1:0] S32_MAX = 56'sd2147483647;
    localparam logic signed [WIDE_W-1:0] S32_MIN = -56'sd2147483648;

    typedef struct packed {
        logic [30:0] max_position_deviation;
        logic [19:0] cycle_rate;
        logic [31:0] cycle_period_q32;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] target_position;
        logic signed [31:0] target_velocity;
        logic signed [31:0] target_torque;
    } item_t;

    function automatic logic signed [31:0] sat_s32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < S32_MIN)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/srvemu_if.sv
// ----------------------------------------------------------------------------
// Servo drive emulator channels
// Command beat channel and feedback beat channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface srvemu_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [31:0] target_position;
    logic signed [31:0] target_velocity;
    logic signed [31:0] target_torque;

    modport source (output valid, command, target_position, target_velocity,
                    target_torque, input ready);
    modport sink   (input valid, command, target_position, target_velocity,
                    target_torque, output ready);
endinterface

interface srvemu_fb_if;
    logic               valid;
    logic               ready;
    logic [2:0]         drive_status;
    logic signed [31:0] actual_position;
    logic signed [31:0] actual_velocity;
    logic signed [31:0] actual_torque;
    logic signed [31:0] effective_position;
    logic signed [31:0] effective_velocity;
    logic signed [31:0] effective_torque;

    modport source (output valid, drive_status, actual_position, actual_velocity,
                    actual_torque, effective_position, effective_velocity,
                    effective_torque, input ready);
    modport sink   (input valid, drive_status, actual_position, actual_velocity,
                    actual_torque, effective_position, effective_velocity,
                    effective_torque, output ready);
endinterface

>>> hw/rtl/srvemu_cfg_regs.sv
// ----------------------------------------------------------------------------
// Servo drive emulator configuration registers
// Write-only register file for deviation limit, cycle rate and cycle period.
// ----------------------------------------------------------------------------
module srvemu_cfg_regs
    import srvemu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // zero position only seeds feedback at reset, where it is zero: drop the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ZERO_POSITION: cfg_next = cfg_reg;
                REG_MAX_DEVIATION: cfg_next.max_position_deviation = cfg_data[30:0];
                REG_CYCLE_RATE:    cfg_next.cycle_rate = cfg_data[19:0];
                REG_CYCLE_PERIOD:  cfg_next.cycle_period_q32 = cfg_data[31:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_position_deviation <= MAX_DEVIATION_RESET;
            cfg_reg.cycle_rate             <= CYCLE_RATE_RESET;
            cfg_reg.cycle_period_q32       <= CYCLE_PERIOD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/srvemu_in_reg.sv
// ----------------------------------------------------------------------------
// Servo drive emulator input register
// Capture one command beat and hold it until the drive core takes it.
// ----------------------------------------------------------------------------
module srvemu_in_reg
    import srvemu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    srvemu_cmd_if.sink        cmd,
    input  logic              advance,
    output item_t             item,
    output logic              item_valid
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign cmd.ready  = !valid_reg || advance;
    assign accept     = cmd.valid && cmd.ready;
    assign valid_next = accept || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.command         <= cmd.command;
            item_reg.target_position <= cmd.target_position;
            item_reg.target_velocity <= cmd.target_velocity;
            item_reg.target_torque   <= cmd.target_torque;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

>>> hw/rtl/srvemu_core.sv
// ----------------------------------------------------------------------------
// Servo drive emulator core
// Drive state machine, CSP deviation check and per-mode feedback update.
// The state registers double as the feedback beat register.
// ----------------------------------------------------------------------------
module srvemu_core
    import srvemu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  item_t             item,
    input  logic              item_valid,
    input  cfg_t              cfg,
    output logic              advance,
    srvemu_fb_if.source       fb
);

    typedef enum logic [2:0] {
        S_NOTREADY = ST_NOTREADY,
        S_LOGIC    = ST_LOGIC,
        S_LOCKED   = ST_LOCKED,
        S_CSP      = ST_CSP,
        S_CST      = ST_CST,
        S_CSV      = ST_CSV,
        S_ERROR    = ST_ERROR
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    state_t             trans_state;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] pos_reg;
    logic signed [31:0] pos_next;
    logic signed [31:0] vel_reg;
    logic signed [31:0] vel_next;
    logic signed [31:0] tor_reg;
    logic signed [31:0] tor_next;

    logic signed [32:0] pos_diff;
    logic        [32:0] pos_mag;
    logic               dev_fault;
    logic signed [32:0] pos_delta;
    logic signed [20:0] rate_s;
    logic signed [53:0] vel_prod;
    logic        [31:0] vel_mag;
    logic        [63:0] step_prod;
    logic        [31:0] step;
    logic signed [32:0] adv;
    logic signed [33:0] pos_sum;

    assign advance = item_valid && (!out_valid_reg || fb.ready);

    assign pos_diff  = 33'(pos_reg) - 33'(item.target_position);
    assign pos_mag   = pos_diff[32] ? 33'(-pos_diff) : 33'(pos_diff);
    assign dev_fault = pos_mag > {2'b00, cfg.max_position_deviation};
    assign pos_delta = -pos_diff;
    assign rate_s    = $signed({1'b0, cfg.cycle_rate});
    assign vel_prod  = 54'(pos_delta) * 54'(rate_s);

    assign vel_mag   = vel_reg[31] ? 32'(-vel_reg) : 32'(vel_reg);
    assign step_prod = 64'(vel_mag) * 64'(cfg.cycle_period_q32);
    assign step      = step_prod[63:32];
    assign adv       = vel_reg[31] ? -$signed({1'b0, step}) : $signed({1'b0, step});
    assign pos_sum   = 34'(pos_reg) + 34'(adv);

    always_comb
    begin
        trans_state = state_reg;
        unique case (state_reg) inside
            S_NOTREADY:
            begin
                trans_state = S_LOGIC;
            end
            S_LOGIC:
            begin
                if (item.command == CMD_SYNC)
                begin
                    trans_state = S_LOCKED;
                end
            end
            S_LOCKED, S_CSP:
            begin
                case (item.command)
                    CMD_OFF: trans_state = S_LOCKED;
                    CMD_CSP: trans_state = S_CSP;
                    CMD_CST: trans_state = S_CST;
                    CMD_CSV: trans_state = S_CSV;
                    default: trans_state = state_reg;
                endcase
            end
            S_ERROR:
            begin
                trans_state = S_LOCKED;
            end
            default:
            begin
                trans_state = state_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        tor_next       = tor_reg;
        out_valid_next = out_valid_reg && !fb.ready;
        if (advance)
        begin
            out_valid_next = 1'b1;
            state_next     = trans_state;
            if (trans_state == S_CSP && dev_fault)
            begin
                state_next = S_ERROR;
            end
            else if (trans_state == S_CSP)
            begin
                vel_next = sat_s32(56'(vel_prod));
                pos_next = item.target_position;
            end
            else if (trans_state == S_CSV)
            begin
                pos_next = sat_s32(56'(pos_sum));
                vel_next = item.target_velocity;
            end
            else if (trans_state == S_CST)
            begin
                tor_next = item.target_torque;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_NOTREADY;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            tor_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
            tor_reg       <= tor_next;
        end
    end

    assign fb.valid              = out_valid_reg;
    assign fb.drive_status       = state_reg;
    assign fb.actual_position    = pos_reg;
    assign fb.actual_velocity    = vel_reg;
    assign fb.actual_torque      = tor_reg;
    assign fb.effective_position = pos_reg;
    assign fb.effective_velocity = vel_reg;
    assign fb.effective_torque   = tor_reg;

endmodule

>>> hw/rtl/servo_drive_cycle_emulator.sv
// ----------------------------------------------------------------------------
// Servo drive cycle emulator
// Emulates one servo drive over fieldbus communication cycles.
//
// cmd carries one beat per communication cycle: decoded command plus position,
// velocity and torque targets. fb returns one beat per command beat: drive
// status, feedback and applied position, velocity and torque.
// Path: a command beat passes the input register, then the state/feedback
// register, which holds its feedback beat until fb takes it.
// Throughput: one beat per clock unless fb is held off; the state update,
// CSP rate and CSV period products are combinational between the registers.
// Reset: drive status not ready, all feedback and applied values zero, limits
// and cycle timing at their defaults.
// Stall: while fb is held off, at most one more command beat is taken into
// the input register, then cmd.ready drops until the feedback beat is taken.
// cfg_write/cfg_index/cfg_data write the registers; write only while idle.
// ----------------------------------------------------------------------------
module servo_drive_cycle_emulator
    import srvemu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    srvemu_cmd_if.sink             cmd,
    srvemu_fb_if.source            fb
);

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  advance;

    srvemu_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srvemu_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .advance    (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    srvemu_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .cfg        (cfg),
        .advance    (advance),
        .fb         (fb)
    );

endmodule

>>> hw/rtl/srvemu_checker.sv
// ----------------------------------------------------------------------------
// Servo drive emulator port checker
// Port-level properties of the emulator, bound to the top level.
// ----------------------------------------------------------------------------
module srvemu_checker
    import srvemu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    srvemu_cmd_if.sink  cmd,
    srvemu_fb_if.source fb
);

    a_no_notready_beat: assert property (@(posedge clk) disable iff (!rst_n)
        fb.valid |-> fb.drive_status != ST_NOTREADY)
        else $error("feedback beat reports not-ready status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        fb.valid |-> fb.drive_status != ST_UNUSED)
        else $error("feedback beat reports unused status code");

    a_backpressure_only: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (fb.valid && !fb.ready))
        else $error("command channel stalled without feedback stall");

    a_fb_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fb.valid && !fb.ready) |=> (fb.valid && $stable(fb.drive_status)
            && $stable(fb.actual_position) && $stable(fb.actual_velocity)
            && $stable(fb.actual_torque)))
        else $error("stalled feedback beat changed");

endmodule

bind servo_drive_cycle_emulator srvemu_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .fb    (fb)
);
